// ===== hdl/hbffa_pkg.sv =====
// Shared constants, codes and types for the handle block first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package hbffa_pkg;

	// default sizing
	localparam int HANDLE_COUNT_DEF = 128;
	localparam int POOL_KB_DEF      = 2048;
	localparam int BASE_KB_DEF      = 1024;
	localparam int RESERVED_KB_DEF  = 64;

	// field widths
	localparam int ACT_W    = 3;
	localparam int HANDLE_W = 16;
	localparam int REQ_W    = 16;
	localparam int ERR_W    = 2;
	localparam int GRANT_W  = 7;
	localparam int KB_W     = 12;
	localparam int LOCK_W   = 8;
	localparam int ADDR_W   = 22;
	localparam int KB_SHIFT = 10;   // KB to byte address
	localparam int ALU_W    = 16;

	// action codes
	localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_FREE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_LOCK   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_UNLOCK = 3'd3;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_INFO   = 3'd5;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
	localparam logic [ERR_W-1:0] ERR_SPACE  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_HANDLE = 2'd2;

	typedef enum logic [1:0] {
		ALU_ADD     = 2'd0,
		ALU_SUB     = 2'd1,
		ALU_INC_SAT = 2'd2,
		ALU_DEC_SAT = 2'd3
	} alu_op_t;

	typedef struct packed {
		logic ge;
		logic gt;
	} alu_flags_t;

	typedef struct packed {
		logic start_we;
		logic size_we;
		logic lock_we;
	} tbl_we_t;

endpackage
`default_nettype wire

// ===== hdl/hbffa_cmd_if.sv =====
// Command channel: action, handle and requested size.
`timescale 1ns / 1ps
`default_nettype none
interface hbffa_cmd_if;
	import hbffa_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACT_W-1:0]    action;
	logic [HANDLE_W-1:0] handle;
	logic [REQ_W-1:0]    request_kb;

	modport source (output valid, action, handle, request_kb, input ready);
	modport sink (input valid, action, handle, request_kb, output ready);
endinterface
`default_nettype wire

// ===== hdl/hbffa_rsp_if.sv =====
// Response channel: status and result fields of one action.
`timescale 1ns / 1ps
`default_nettype none
interface hbffa_rsp_if;
	import hbffa_pkg::*;

	logic               valid;
	logic               ready;
	logic               ok;
	logic [ERR_W-1:0]   error_code;
	logic [GRANT_W-1:0] granted_handle;
	logic [KB_W-1:0]    largest_free_kb;
	logic [LOCK_W-1:0]  lock_count;
	logic [LOCK_W-1:0]  handles_left;
	logic [KB_W-1:0]    block_kb;
	logic [ADDR_W-1:0]  block_address;

	modport source (output valid, ok, error_code, granted_handle, largest_free_kb,
		lock_count, handles_left, block_kb, block_address, input ready);
	modport sink (input valid, ok, error_code, granted_handle, largest_free_kb,
		lock_count, handles_left, block_kb, block_address, output ready);
endinterface
`default_nettype wire

// ===== hdl/hbffa_alu.sv =====
// Shared add/subtract/saturating step unit with magnitude compare.
`timescale 1ns / 1ps
`default_nettype none
module hbffa_alu (
	input  hbffa_pkg::alu_op_t            op,
	input  logic [hbffa_pkg::ALU_W-1:0]   a,
	input  logic [hbffa_pkg::ALU_W-1:0]   b,
	output logic [hbffa_pkg::ALU_W-1:0]   y,
	output hbffa_pkg::alu_flags_t         flags
);
	import hbffa_pkg::*;

	always_comb begin
		unique case (op)
			ALU_ADD:     y = a + b;
			ALU_SUB:     y = a - b;
			ALU_INC_SAT: y = (a[LOCK_W-1:0] == {LOCK_W{1'b1}}) ?
				ALU_W'(a[LOCK_W-1:0]) : ALU_W'(a[LOCK_W-1:0] + LOCK_W'(1));
			ALU_DEC_SAT: y = (a[LOCK_W-1:0] == '0) ?
				'0 : ALU_W'(a[LOCK_W-1:0] - LOCK_W'(1));
			default:     y = a;
		endcase
	end

	assign flags.ge = (a >= b);
	assign flags.gt = (a > b);

endmodule
`default_nettype wire

// ===== hdl/hbffa_table.sv =====
// Per-handle start, size and lock memories with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module hbffa_table #(
	parameter  int HANDLE_COUNT = hbffa_pkg::HANDLE_COUNT_DEF,
	parameter  int POOL_KB      = hbffa_pkg::POOL_KB_DEF,
	parameter  int BASE_KB      = hbffa_pkg::BASE_KB_DEF,
	parameter  int RESERVED_KB  = hbffa_pkg::RESERVED_KB_DEF,
	localparam int IW           = $clog2(HANDLE_COUNT)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hbffa_pkg::tbl_we_t            we,
	input  logic [IW-1:0]                 wr_addr,
	input  logic [hbffa_pkg::KB_W-1:0]    wr_start,
	input  logic [hbffa_pkg::KB_W-1:0]    wr_size,
	input  logic [hbffa_pkg::LOCK_W-1:0]  wr_lock,
	input  logic [IW-1:0]                 rd_addr,
	output logic [hbffa_pkg::KB_W-1:0]    rd_start,
	output logic [hbffa_pkg::KB_W-1:0]    rd_size,
	output logic [hbffa_pkg::LOCK_W-1:0]  rd_lock
);
	import hbffa_pkg::*;

	// entries 0 and 1 come out of reset with fixed contents
	localparam logic [KB_W-1:0] START0 = KB_W'(BASE_KB);
	localparam logic [KB_W-1:0] START1 = KB_W'(BASE_KB + RESERVED_KB);
	localparam logic [KB_W-1:0] SIZE0  = KB_W'(RESERVED_KB);
	localparam logic [KB_W-1:0] SIZE1  = KB_W'(POOL_KB - RESERVED_KB);

	logic [KB_W-1:0]   start_mem [HANDLE_COUNT];
	logic [KB_W-1:0]   size_mem  [HANDLE_COUNT];
	logic [LOCK_W-1:0] lock_mem  [HANDLE_COUNT];

	logic [1:0]        st_wr_q, sz_wr_q, lk_wr_q;
	logic              st_dflt_s1, sz_dflt_s1, lk_dflt_s1, b0_s1;
	logic [KB_W-1:0]   st_raw_s1, sz_raw_s1;
	logic [LOCK_W-1:0] lk_raw_s1;
	logic              wr_lo, rd_lo;

	assign wr_lo = (wr_addr < IW'(2));
	assign rd_lo = (rd_addr < IW'(2));

	always_ff @(posedge clk) begin
		if (we.start_we) start_mem[wr_addr] <= wr_start;
		if (we.size_we)  size_mem[wr_addr]  <= wr_size;
		if (we.lock_we)  lock_mem[wr_addr]  <= wr_lock;
		st_raw_s1 <= start_mem[rd_addr];
		sz_raw_s1 <= size_mem[rd_addr];
		lk_raw_s1 <= lock_mem[rd_addr];
		b0_s1     <= rd_addr[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_wr_q    <= '0;
			sz_wr_q    <= '0;
			lk_wr_q    <= '0;
			st_dflt_s1 <= 1'b0;
			sz_dflt_s1 <= 1'b0;
			lk_dflt_s1 <= 1'b0;
		end else begin
			if (we.start_we && wr_lo) st_wr_q[wr_addr[0]] <= 1'b1;
			if (we.size_we && wr_lo)  sz_wr_q[wr_addr[0]] <= 1'b1;
			if (we.lock_we && wr_lo)  lk_wr_q[wr_addr[0]] <= 1'b1;
			st_dflt_s1 <= rd_lo && !st_wr_q[rd_addr[0]];
			sz_dflt_s1 <= rd_lo && !sz_wr_q[rd_addr[0]];
			lk_dflt_s1 <= rd_lo && !lk_wr_q[rd_addr[0]];
		end
	end

	assign rd_start = st_dflt_s1 ? (b0_s1 ? START1 : START0) : st_raw_s1;
	assign rd_size  = sz_dflt_s1 ? (b0_s1 ? SIZE1 : SIZE0) : sz_raw_s1;
	assign rd_lock  = lk_dflt_s1 ? '0 : lk_raw_s1;

endmodule
`default_nettype wire

// ===== hdl/handle_block_first_fit_allocator.sv =====
// Top level: handle table sequencer for the first-fit block allocator.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------------
//  cmd     | in  | valid / ready | action, handle, request_kb
//  rsp     | out | valid / ready | ok, error_code, granted_handle, largest_free_kb,
//          |     |               | lock_count, handles_left, block_kb, block_address
//
// One item at a time. Free, lock, unlock and info go from accept to the result
// register through handle check with table read, update and hand-off; a rejected
// handle skips the update. Query walks the size memory, one entry per cycle.
// Allocate walks the used bits for the lowest free handle, then walks the size
// memory for the first fit, then reads the fitting entry and does three writes
// through the single write port and the shared ALU.
// Reset is ready at once: flags sit in flip-flops, entries 0 and 1 of the
// memories read their reset contents until first written; no clearing pass.
// A finished result waits in the output register; the next item is accepted
// meanwhile and only its hand-off stalls on a full output register.
`timescale 1ns / 1ps
`default_nettype none
module handle_block_first_fit_allocator #(
	parameter int HANDLE_COUNT = hbffa_pkg::HANDLE_COUNT_DEF,
	parameter int POOL_KB      = hbffa_pkg::POOL_KB_DEF,
	parameter int BASE_KB      = hbffa_pkg::BASE_KB_DEF,
	parameter int RESERVED_KB  = hbffa_pkg::RESERVED_KB_DEF
) (
	input logic         clk,
	input logic         arst_n,
	hbffa_cmd_if.sink   cmd,
	hbffa_rsp_if.source rsp
);
	import hbffa_pkg::*;

	localparam int IW = $clog2(HANDLE_COUNT);       // entry index
	localparam int CW = $clog2(HANDLE_COUNT + 1);   // scan counter, reaches N
	localparam logic [HANDLE_COUNT-1:0] USED_RST = HANDLE_COUNT'(3);
	localparam logic [HANDLE_COUNT-1:0] FREE_RST = HANDLE_COUNT'(2);
	localparam logic [LOCK_W-1:0] AVAIL_RST =
		(HANDLE_COUNT - 2 > 255) ? 8'd255 : LOCK_W'(HANDLE_COUNT - 2);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_CHK   = 11'b000_0000_0010,
		S_HOP   = 11'b000_0000_0100,
		S_UNUSED= 11'b000_0000_1000,
		S_FIT   = 11'b000_0001_0000,
		S_ALRD  = 11'b000_0010_0000,
		S_ALWR1 = 11'b000_0100_0000,
		S_ALWR2 = 11'b000_1000_0000,
		S_ALWR3 = 11'b001_0000_0000,
		S_QUERY = 11'b010_0000_0000,
		S_EMIT  = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic               ok;
		logic [ERR_W-1:0]   error_code;
		logic [GRANT_W-1:0] granted_handle;
		logic [KB_W-1:0]    largest_free_kb;
		logic [LOCK_W-1:0]  lock_count;
		logic [LOCK_W-1:0]  handles_left;
		logic [KB_W-1:0]    block_kb;
		logic [ADDR_W-1:0]  block_address;
	} rsp_t;

	state_t              state_q;
	logic [CW-1:0]       k_q;
	logic                vld_s1, flag_s1;
	logic [IW-1:0]       idx_s1;
	logic [HANDLE_COUNT-1:0] used_q, free_q;
	logic [LOCK_W-1:0]   avail_q;
	logic                out_valid_q;
	logic [ACT_W-1:0]    act_q;
	logic [HANDLE_W-1:0] h_q;
	logic [REQ_W-1:0]    req_q;
	logic [IW-1:0]       n_q, i_q;
	logic [KB_W-1:0]     sz_i_q, best_q;
	rsp_t                pend_q, out_q;

	// shared ALU
	alu_op_t             alu_op;
	logic [ALU_W-1:0]    alu_a, alu_b, alu_y;
	alu_flags_t          alu_fl;

	// table port
	tbl_we_t             we;
	logic [IW-1:0]       wr_addr, rd_addr;
	logic [KB_W-1:0]     wr_start, wr_size, rd_start, rd_size;
	logic [LOCK_W-1:0]   wr_lock, rd_lock;

	// decisions
	logic [IW-1:0]       hx, kx;
	logic                cmd_acc, slot_free, k_end, scan_done;
	logic                fit_hit, qry_upd, unused_hit, unused_last, hok;

	hbffa_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.y     (alu_y),
		.flags (alu_fl)
	);

	hbffa_table #(
		.HANDLE_COUNT (HANDLE_COUNT),
		.POOL_KB      (POOL_KB),
		.BASE_KB      (BASE_KB),
		.RESERVED_KB  (RESERVED_KB)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (we),
		.wr_addr  (wr_addr),
		.wr_start (wr_start),
		.wr_size  (wr_size),
		.wr_lock  (wr_lock),
		.rd_addr  (rd_addr),
		.rd_start (rd_start),
		.rd_size  (rd_size),
		.rd_lock  (rd_lock)
	);

	assign hx          = h_q[IW-1:0];
	assign kx          = k_q[IW-1:0];
	assign cmd_acc     = cmd.valid && cmd.ready;
	assign slot_free   = !out_valid_q || rsp.ready;
	assign k_end       = (k_q == CW'(HANDLE_COUNT));
	assign scan_done   = k_end && !vld_s1;
	// compare stage of the scan: size read in the cycle after its issue
	assign fit_hit     = vld_s1 && flag_s1 && alu_fl.ge;
	assign qry_upd     = vld_s1 && flag_s1 && alu_fl.gt;
	assign unused_hit  = !used_q[kx];
	assign unused_last = (k_q == CW'(HANDLE_COUNT - 1));
	assign hok         = (h_q < HANDLE_W'(HANDLE_COUNT)) && used_q[hx];

	// ALU operands and table accesses per state
	always_comb begin
		alu_op   = ALU_ADD;
		alu_a    = ALU_W'(rd_size);
		alu_b    = req_q;
		rd_addr  = kx;
		we       = '0;
		wr_addr  = n_q;
		wr_start = alu_y[KB_W-1:0];
		wr_size  = alu_y[KB_W-1:0];
		wr_lock  = alu_y[LOCK_W-1:0];
		unique case (state_q)
			S_QUERY: alu_b = ALU_W'(best_q);
			S_CHK:   rd_addr = hx;
			S_HOP: begin
				wr_addr = hx;
				unique case (act_q)
					ACT_FREE: begin
						alu_op = ALU_INC_SAT;
						alu_a  = ALU_W'(avail_q);
					end
					ACT_LOCK: begin
						alu_op     = ALU_INC_SAT;
						alu_a      = ALU_W'(rd_lock);
						we.lock_we = 1'b1;
					end
					ACT_UNLOCK: begin
						alu_op     = ALU_DEC_SAT;
						alu_a      = ALU_W'(rd_lock);
						we.lock_we = 1'b1;
					end
					default: ;
				endcase
			end
			S_ALRD: rd_addr = i_q;
			S_ALWR1: begin
				// remainder entry: start past the granted part, no locks
				alu_a       = ALU_W'(rd_start);
				we.start_we = 1'b1;
				we.lock_we  = 1'b1;
				wr_lock     = '0;
			end
			S_ALWR2: begin
				alu_op     = ALU_SUB;
				alu_a      = ALU_W'(sz_i_q);
				we.size_we = 1'b1;
			end
			S_ALWR3: begin
				// granted entry shrinks to the request
				alu_op     = ALU_DEC_SAT;
				alu_a      = ALU_W'(avail_q);
				wr_addr    = i_q;
				we.size_we = 1'b1;
				wr_size    = req_q[KB_W-1:0];
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			vld_s1      <= 1'b0;
			used_q      <= USED_RST;
			free_q      <= FREE_RST;
			avail_q     <= AVAIL_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						k_q    <= '0;
						vld_s1 <= 1'b0;
						priority if (cmd.action == ACT_ALLOC) state_q <= S_UNUSED;
						else if (cmd.action == ACT_QUERY)     state_q <= S_QUERY;
						else if (cmd.action > ACT_INFO)       state_q <= S_EMIT;
						else                                  state_q <= S_CHK;
					end
				end
				S_CHK: state_q <= hok ? S_HOP : S_EMIT;
				S_HOP: begin
					if (act_q == ACT_FREE) begin
						free_q[hx] <= 1'b1;
						avail_q    <= alu_y[LOCK_W-1:0];
					end
					state_q <= S_EMIT;
				end
				S_UNUSED: begin
					if (unused_hit) begin
						k_q     <= '0;
						vld_s1  <= 1'b0;
						state_q <= S_FIT;
					end else if (unused_last) begin
						state_q <= S_EMIT;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_FIT, S_QUERY: begin
					if (state_q == S_FIT && fit_hit) begin
						state_q <= S_ALRD;
					end else if (scan_done) begin
						state_q <= S_EMIT;
					end else begin
						vld_s1 <= !k_end;
						if (!k_end) k_q <= k_q + CW'(1);
					end
				end
				S_ALRD:  state_q <= S_ALWR1;
				S_ALWR1: begin
					used_q[n_q] <= 1'b1;
					free_q[n_q] <= 1'b1;
					state_q     <= S_ALWR2;
				end
				S_ALWR2: state_q <= S_ALWR3;
				S_ALWR3: begin
					free_q[i_q] <= 1'b0;
					avail_q     <= alu_y[LOCK_W-1:0];
					state_q     <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operands, scan pipeline payload and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					act_q  <= cmd.action;
					h_q    <= cmd.handle;
					req_q  <= cmd.request_kb;
					pend_q <= '0;
					best_q <= '0;
				end
			end
			S_CHK: if (!hok) pend_q.error_code <= ERR_HANDLE;
			S_HOP: begin
				pend_q.ok <= 1'b1;
				unique case (act_q)
					ACT_LOCK: begin
						pend_q.lock_count    <= alu_y[LOCK_W-1:0];
						pend_q.block_address <= ADDR_W'({rd_start, {KB_SHIFT{1'b0}}});
					end
					ACT_UNLOCK: pend_q.lock_count <= alu_y[LOCK_W-1:0];
					ACT_INFO: begin
						pend_q.lock_count   <= rd_lock;
						pend_q.handles_left <= avail_q;
						pend_q.block_kb     <= rd_size;
					end
					default: ;
				endcase
			end
			S_UNUSED: begin
				if (unused_hit)       n_q <= kx;
				else if (unused_last) pend_q.error_code <= ERR_SPACE;
			end
			S_FIT: begin
				flag_s1 <= used_q[kx] && free_q[kx];
				idx_s1  <= kx;
				if (fit_hit) begin
					i_q    <= idx_s1;
					sz_i_q <= rd_size;
				end else if (scan_done) begin
					pend_q.error_code <= ERR_SPACE;
				end
			end
			S_QUERY: begin
				flag_s1 <= used_q[kx] && free_q[kx];
				idx_s1  <= kx;
				if (qry_upd) best_q <= rd_size;
				if (scan_done) begin
					pend_q.ok              <= 1'b1;
					pend_q.largest_free_kb <= best_q;
				end
			end
			S_ALWR3: begin
				pend_q.ok             <= 1'b1;
				pend_q.granted_handle <= GRANT_W'(ALU_W'(i_q));
			end
			S_EMIT: if (slot_free) out_q <= pend_q;
			default: ;
		endcase
	end

	assign cmd.ready           = (state_q == S_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.ok              = out_q.ok;
	assign rsp.error_code      = out_q.error_code;
	assign rsp.granted_handle  = out_q.granted_handle;
	assign rsp.largest_free_kb = out_q.largest_free_kb;
	assign rsp.lock_count      = out_q.lock_count;
	assign rsp.handles_left    = out_q.handles_left;
	assign rsp.block_kb        = out_q.block_kb;
	assign rsp.block_address   = out_q.block_address;

endmodule
`default_nettype wire

// ===== hdl/hbffa_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hbffa_checker #(
	parameter int RSP_W = 1 + hbffa_pkg::ERR_W + hbffa_pkg::GRANT_W + 2 * hbffa_pkg::KB_W
		+ 2 * hbffa_pkg::LOCK_W + hbffa_pkg::ADDR_W
) (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [RSP_W-1:0] rsp_bits
);
	logic [1:0] out_cnt_q;   // items accepted, result not yet taken
	logic       cmd_acc, rsp_acc;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_cnt_q <= '0;
		else         out_cnt_q <= out_cnt_q + 2'(cmd_acc) - 2'(rsp_acc);
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_bits))
		else $error("response changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> !cmd_ready)
		else $error("ready right after an accepted item");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> out_cnt_q != 2'd0)
		else $error("response without an accepted item");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> out_cnt_q != 2'd2)
		else $error("ready with two items outstanding");

endmodule

bind handle_block_first_fit_allocator hbffa_checker u_hbffa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_bits  ({rsp.ok, rsp.error_code, rsp.granted_handle, rsp.largest_free_kb,
		rsp.lock_count, rsp.handles_left, rsp.block_kb, rsp.block_address})
);
`default_nettype wire

// ===== tb/sv/hbffa_table_shadow_check.sv =====
// Shadow handle table: predicts each response from accepted commands and compares.
`timescale 1ns / 1ps
module hbffa_table_shadow_check #(
	parameter int HANDLE_COUNT = hbffa_pkg::HANDLE_COUNT_DEF,
	parameter int POOL_KB      = hbffa_pkg::POOL_KB_DEF,
	parameter int BASE_KB      = hbffa_pkg::BASE_KB_DEF,
	parameter int RESERVED_KB  = hbffa_pkg::RESERVED_KB_DEF
) (
	input logic  clk,
	input logic  arst_n,
	hbffa_cmd_if cmd,
	hbffa_rsp_if rsp,
	output int   mismatch_count,
	output int   rsp_seen,
	output int   rsp_pending
);
	import hbffa_pkg::*;

	localparam logic [LOCK_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic               ok;
		logic [ERR_W-1:0]   error_code;
		logic [GRANT_W-1:0] granted_handle;
		logic [KB_W-1:0]    largest_free_kb;
		logic [LOCK_W-1:0]  lock_count;
		logic [LOCK_W-1:0]  handles_left;
		logic [KB_W-1:0]    block_kb;
		logic [ADDR_W-1:0]  block_address;
	} rsp_fields_t;

	logic              slot_used     [HANDLE_COUNT];
	logic              slot_free     [HANDLE_COUNT];
	logic [KB_W-1:0]   slot_start_kb [HANDLE_COUNT];
	logic [KB_W-1:0]   slot_size_kb  [HANDLE_COUNT];
	logic [LOCK_W-1:0] slot_locks    [HANDLE_COUNT];
	logic [LOCK_W-1:0] handles_avail;
	rsp_fields_t       expected_rsp  [$];
	rsp_fields_t       want;

	task automatic clear_table();
		int i;
		for (i = 0; i < HANDLE_COUNT; i++) begin
			slot_used[i]     = 1'b0;
			slot_free[i]     = 1'b0;
			slot_start_kb[i] = '0;
			slot_size_kb[i]  = '0;
			slot_locks[i]    = '0;
		end
		slot_used[0]     = 1'b1;
		slot_used[1]     = 1'b1;
		slot_free[1]     = 1'b1;
		slot_start_kb[0] = KB_W'(BASE_KB);
		slot_size_kb[0]  = KB_W'(RESERVED_KB);
		slot_start_kb[1] = KB_W'(BASE_KB + RESERVED_KB);
		slot_size_kb[1]  = KB_W'(POOL_KB - RESERVED_KB);
		handles_avail    = (HANDLE_COUNT - 2 > 255) ? 8'd255 : LOCK_W'(HANDLE_COUNT - 2);
	endtask

	// Applies one command to the shadow table and returns the response it owes.
	function automatic rsp_fields_t step_handle_table(input logic [ACT_W-1:0] act,
			input logic [HANDLE_W-1:0] h, input logic [REQ_W-1:0] req);
		rsp_fields_t r;
		int i;
		int fit;
		int spare;
		int idx;
		logic [KB_W-1:0] best;
		r     = '0;
		fit   = -1;
		spare = -1;
		idx   = int'(h);
		best  = '0;
		case (act)
		ACT_ALLOC: begin
			for (i = 0; i < HANDLE_COUNT && fit < 0; i++)
				if (slot_used[i] && slot_free[i] && {4'b0, slot_size_kb[i]} >= req)
					fit = i;
			for (i = 0; i < HANDLE_COUNT && spare < 0; i++)
				if (!slot_used[i])
					spare = i;
			if (fit < 0 || spare < 0) begin
				r.error_code = ERR_SPACE;
			end else begin
				// remainder is split off even when it is empty
				slot_used[spare]     = 1'b1;
				slot_free[spare]     = 1'b1;
				slot_locks[spare]    = '0;
				slot_start_kb[spare] = slot_start_kb[fit] + req[KB_W-1:0];
				slot_size_kb[spare]  = slot_size_kb[fit] - req[KB_W-1:0];
				slot_size_kb[fit]    = req[KB_W-1:0];
				slot_free[fit]       = 1'b0;
				if (handles_avail != 0)
					handles_avail--;
				r.ok             = 1'b1;
				r.granted_handle = GRANT_W'(fit);
			end
		end
		ACT_QUERY: begin
			for (i = 0; i < HANDLE_COUNT; i++)
				if (slot_used[i] && slot_free[i] && slot_size_kb[i] > best)
					best = slot_size_kb[i];
			r.ok              = 1'b1;
			r.largest_free_kb = best;
		end
		ACT_FREE, ACT_LOCK, ACT_UNLOCK, ACT_INFO: begin
			if (idx >= HANDLE_COUNT || !slot_used[idx]) begin
				r.error_code = ERR_HANDLE;
			end else begin
				r.ok = 1'b1;
				case (act)
				ACT_FREE: begin
					// double free still counts the pool up
					slot_free[idx] = 1'b1;
					if (handles_avail != COUNT_MAX)
						handles_avail++;
				end
				ACT_LOCK: begin
					if (slot_locks[idx] != COUNT_MAX)
						slot_locks[idx]++;
					r.lock_count    = slot_locks[idx];
					r.block_address = ADDR_W'({slot_start_kb[idx], {KB_SHIFT{1'b0}}});
				end
				ACT_UNLOCK: begin
					if (slot_locks[idx] != 0)
						slot_locks[idx]--;
					r.lock_count = slot_locks[idx];
				end
				default: begin
					r.lock_count   = slot_locks[idx];
					r.handles_left = handles_avail;
					r.block_kb     = slot_size_kb[idx];
				end
				endcase
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic note_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val) begin
			$display("mismatch: result %0d %s got 0x%0h want 0x%0h",
				rsp_seen, field, got, exp_val);
			mismatch_count = mismatch_count + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_table();
			expected_rsp.delete();
			mismatch_count = 0;
			rsp_seen       = 0;
			rsp_pending   <= 0;
		end else begin
			// responses first, so a stray one never meets the item taken this edge
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					$display("mismatch: result %0d arrived with nothing owed", rsp_seen);
					mismatch_count = mismatch_count + 1;
				end else begin
					want = expected_rsp.pop_front();
					note_mismatch("ok", rsp.ok, want.ok);
					note_mismatch("error_code", rsp.error_code, want.error_code);
					note_mismatch("granted_handle", rsp.granted_handle, want.granted_handle);
					note_mismatch("largest_free_kb", rsp.largest_free_kb, want.largest_free_kb);
					note_mismatch("lock_count", rsp.lock_count, want.lock_count);
					note_mismatch("handles_left", rsp.handles_left, want.handles_left);
					note_mismatch("block_kb", rsp.block_kb, want.block_kb);
					note_mismatch("block_address", rsp.block_address, want.block_address);
				end
				rsp_seen = rsp_seen + 1;
			end
			if (cmd.valid && cmd.ready)
				expected_rsp.push_back(step_handle_table(cmd.action, cmd.handle,
					cmd.request_kb));
			rsp_pending <= expected_rsp.size();
		end
	end

endmodule

// ===== tb/sv/handle_block_first_fit_allocator_tb.sv =====
// Testbench top: clock, reset, command stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps
module handle_block_first_fit_allocator_tb;
	import hbffa_pkg::*;

	localparam int CLK_HALF_NS      = 4;
	localparam int RESET_CYCLES     = 8;
	localparam int LONG_HOLD_CYCLES = 600;   // output stall that backs the block up
	localparam int DRAIN_CYCLES     = 300;   // beyond the longest allocate
	localparam int MIX_ITEMS        = 40;    // per random phase, two phases
	localparam int SAT_ROUNDS       = 132;   // two locks and a free per round pin both counters

	// the two action codes the block does not define
	localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   rsp_seen;
	int   rsp_pending;
	int   sent_by_action [8];
	int   items_sent;
	int   used_hint;      // rough top of the used-handle prefix
	bit   send_calm;      // stretch of back-to-back commands
	bit   recv_calm;      // stretch with ready held high
	bit   long_hold_req;  // asks the receiver for the long stall
	int   stall_left;

	hbffa_cmd_if cmd_ch ();
	hbffa_rsp_if rsp_ch ();

	handle_block_first_fit_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	hbffa_table_shadow_check u_shadow (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.rsp_seen       (rsp_seen),
		.rsp_pending    (rsp_pending)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF_NS clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// mostly short idles, now and then a long one
	function automatic int pick_idle();
		if ($urandom_range(0, 99) < 70)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Response back-pressure. One assignment to ready per edge; a stall is
	// counted down here so the long hold runs independent of the sender.
	initial begin
		stall_left     = 0;
		recv_calm      = 1'b0;
		rsp_ch.ready  <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				recv_calm = !recv_calm;
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left    = LONG_HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!recv_calm && $urandom_range(0, 99) < 25) begin
				stall_left    = pick_idle() - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Presents one item, waits for the handshake, then maybe idles. Valid is
	// left high when the next item follows at once, so it is never dropped
	// and raised in the same step.
	task automatic offer_item(input logic [ACT_W-1:0] act, input logic [HANDLE_W-1:0] h,
			input logic [REQ_W-1:0] req);
		int gap;
		cmd_ch.valid      <= 1'b1;
		cmd_ch.action     <= act;
		cmd_ch.handle     <= h;
		cmd_ch.request_kb <= req;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		items_sent++;
		sent_by_action[act]++;
		if (act == ACT_ALLOC && req <= 255 && used_hint < 127)
			used_hint++;
		if ($urandom_range(0, 31) == 0)
			send_calm = !send_calm;
		gap = (!send_calm && $urandom_range(0, 99) < 35) ? pick_idle() : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Used handles always form a prefix, so most picks land inside it.
	function automatic logic [HANDLE_W-1:0] pick_handle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return HANDLE_W'($urandom_range(0, used_hint));
		if (r < 90)
			return HANDLE_W'($urandom_range(used_hint, 140));
		return HANDLE_W'($urandom_range(0, 65535));
	endfunction

	// Small sizes keep the pool and handles alive; a few do not fit at all.
	function automatic logic [REQ_W-1:0] pick_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 50)
			return REQ_W'($urandom_range(1, 16));
		if (r < 75)
			return REQ_W'($urandom_range(17, 200));
		if (r < 88)
			return REQ_W'($urandom_range(201, 2000));
		return REQ_W'($urandom_range(0, 65535));
	endfunction

	// Random traffic: mostly allocate-and-use sequences on live handles,
	// single operations, and some raw noise over every field bit.
	task automatic run_mix(input int count);
		int stop;
		int kind;
		logic [HANDLE_W-1:0] h;
		stop = items_sent + count;
		while (items_sent < stop) begin
			kind = $urandom_range(0, 99);
			h    = pick_handle();
			if (kind < 30) begin
				offer_item(ACT_ALLOC, pick_handle(), pick_request());
				offer_item(ACT_LOCK, h, pick_request());
				offer_item(ACT_INFO, h, pick_request());
				offer_item(ACT_UNLOCK, h, pick_request());
				if ($urandom_range(0, 1) == 1)
					offer_item(ACT_FREE, h, pick_request());
			end else if (kind < 50) begin
				offer_item(ACT_ALLOC, h, pick_request());
			end else if (kind < 65) begin
				offer_item(ACT_FREE, h, pick_request());
			end else if (kind < 72) begin
				offer_item(ACT_LOCK, h, pick_request());
			end else if (kind < 79) begin
				offer_item(ACT_UNLOCK, h, pick_request());
			end else if (kind < 87) begin
				offer_item(ACT_INFO, h, pick_request());
			end else if (kind < 93) begin
				offer_item(ACT_QUERY, h, pick_request());
			end else begin
				offer_item(ACT_W'($urandom_range(0, 7)), HANDLE_W'($urandom_range(0, 65535)),
					REQ_W'($urandom_range(0, 65535)));
			end
		end
	endtask

	initial begin
		int i;
		items_sent         = 0;
		used_hint          = 2;
		send_calm          = 1'b0;
		long_hold_req      = 1'b0;
		for (i = 0; i < 8; i++)
			sent_by_action[i] = 0;
		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.action     <= ACT_QUERY;
		cmd_ch.handle     <= '0;
		cmd_ch.request_kb <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset contents, lock floor, first fit with empty remainder,
		// sizes that cannot fit, bad handles, double free, unknown actions
		offer_item(ACT_QUERY, 16'd0, 16'd0);
		offer_item(ACT_INFO, 16'd0, 16'd0);
		offer_item(ACT_INFO, 16'd1, 16'd0);
		offer_item(ACT_LOCK, 16'd0, 16'd0);
		offer_item(ACT_UNLOCK, 16'd0, 16'd0);
		offer_item(ACT_UNLOCK, 16'd0, 16'd0);
		offer_item(ACT_LOCK, 16'd1, 16'd0);
		offer_item(ACT_ALLOC, 16'd0, 16'd0);
		offer_item(ACT_ALLOC, 16'd0, 16'd100);
		offer_item(ACT_ALLOC, 16'd0, 16'hFFFF);
		offer_item(ACT_ALLOC, 16'd0, 16'd4095);
		offer_item(ACT_INFO, 16'd127, 16'd0);
		offer_item(ACT_INFO, 16'hFFFF, 16'd0);
		offer_item(ACT_FREE, 16'd128, 16'd0);
		offer_item(ACT_LOCK, 16'd200, 16'd0);
		offer_item(ACT_FREE, 16'd2, 16'd0);
		offer_item(ACT_FREE, 16'd2, 16'd0);
		offer_item(ACT_ALLOC, 16'd0, 16'd100);
		offer_item(ACT_SPARE_6, 16'hFFFF, 16'hFFFF);
		offer_item(ACT_SPARE_7, 16'd0, 16'd0);
		offer_item(ACT_FREE, 16'd0, 16'd0);
		offer_item(ACT_ALLOC, 16'd0, 16'd64);
		offer_item(ACT_INFO, 16'd3, 16'd0);
		offer_item(ACT_QUERY, 16'd0, 16'd0);
		offer_item(ACT_UNLOCK, 16'd1, 16'd0);
		used_hint = 5;

		// pin the lock count of handle 0 and the free-handle count at 255
		for (i = 0; i < SAT_ROUNDS; i++) begin
			offer_item(ACT_LOCK, 16'd0, REQ_W'($urandom_range(0, 65535)));
			offer_item(ACT_LOCK, 16'd0, REQ_W'($urandom_range(0, 65535)));
			offer_item(ACT_FREE, 16'd1, REQ_W'($urandom_range(0, 65535)));
		end
		offer_item(ACT_INFO, 16'd0, 16'd0);
		offer_item(ACT_UNLOCK, 16'd0, 16'd0);
		offer_item(ACT_INFO, 16'd1, 16'd0);

		// first random phase opens with the long output stall
		long_hold_req = 1'b1;
		run_mix(MIX_ITEMS);

		run_mix(MIX_ITEMS);
		cmd_ch.valid <= 1'b0;

		// drain, then give a stray late response time to show up
		do
			@(posedge clk);
		while (rsp_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d items (alloc %0d, free %0d, lock %0d, unlock %0d, query %0d,",
			items_sent, sent_by_action[ACT_ALLOC], sent_by_action[ACT_FREE],
			sent_by_action[ACT_LOCK], sent_by_action[ACT_UNLOCK], sent_by_action[ACT_QUERY]);
		$display("summary: info %0d, undefined %0d); %0d responses checked, %0d-cycle stall",
			sent_by_action[ACT_INFO], sent_by_action[ACT_SPARE_6] + sent_by_action[ACT_SPARE_7],
			rsp_seen, LONG_HOLD_CYCLES);
		if (mismatch_count == 0 && rsp_pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
